>>> rtl/core/v3n_pkg.sv
package v3n_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int SUM_W      = 2 * WORD_W;
    localparam int REM_W      = WORD_W + 2;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int SQRT_STEPS = WORD_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int LANES      = 3;

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] comp;
        logic                         polar;
    } t_pass;

    typedef struct packed {
        t_pass             pass;
        logic [SUM_W-1:0]  s;
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        t_pass                        pass;
        logic [WORD_W-1:0]            mag;
        logic [LANES-1:0][WORD_W:0]   r;
        logic [LANES-1:0][Q_W-1:0]    q;
    } t_div_st;

    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] a;
        a = w[WORD_W-1] ? (~w + WORD_W'(1)) : w;
        return a;
    endfunction

endpackage

>>> rtl/core/v3n_in_if.sv
interface v3n_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic               is_polar;

    modport source (output valid, x_in, y_in, z_in, is_polar, input ready);
    modport sink   (input valid, x_in, y_in, z_in, is_polar, output ready);
endinterface

>>> rtl/core/v3n_out_if.sv
interface v3n_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic        [31:0] length;

    modport source (output valid, x_out, y_out, z_out, length, input ready);
    modport sink   (input valid, x_out, y_out, z_out, length, output ready);
endinterface

>>> rtl/core/v3n_prep.sv
module v3n_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  v3n_pkg::t_pass   i_pass,
    output logic             o_valid,
    output v3n_pkg::t_sqrt_st o_st
);
    import v3n_pkg::*;

    logic [LANES-1:0][SUM_W-1:0] n_sq;
    logic [LANES-1:0][SUM_W-1:0] r_sq;
    t_pass                       r_pass1;
    t_pass                       r_pass2;
    logic [SUM_W-1:0]            r_sum;
    logic                        r_v1;
    logic                        r_v2;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_sq[k] = SUM_W'(abs_word(i_pass.comp[k])) * SUM_W'(abs_word(i_pass.comp[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= n_sq;
            r_pass1 <= i_pass;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_pass2 <= r_pass1;
        end
    end

    assign o_valid     = r_v2;
    assign o_st.pass   = r_pass2;
    assign o_st.s      = r_sum;
    assign o_st.rem    = '0;
    assign o_st.root   = '0;
endmodule

>>> rtl/core/v3n_sqrt_cell.sv
module v3n_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  v3n_pkg::t_sqrt_st i_st,
    output logic              o_valid,
    output v3n_pkg::t_sqrt_st o_st
);
    import v3n_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    t_sqrt_st         n_st;
    t_sqrt_st         r_st;
    logic             r_valid;

    always_comb begin
        rem_sh    = {i_st.rem, i_st.s[SUM_W-1 -: 2]};
        trial     = {2'b00, i_st.root, 2'b01};
        n_st.pass = i_st.pass;
        n_st.s    = {i_st.s[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_st.rem  = REM_W'(rem_sh - trial);
            n_st.root = {i_st.root[WORD_W-2:0], 1'b1};
        end else begin
            n_st.rem  = rem_sh[REM_W-1:0];
            n_st.root = {i_st.root[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;
endmodule

>>> rtl/core/v3n_div_cell.sv
module v3n_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  v3n_pkg::t_div_st i_st,
    output logic             o_valid,
    output v3n_pkg::t_div_st o_st
);
    import v3n_pkg::*;

    t_div_st         n_st;
    t_div_st         r_st;
    logic            r_valid;
    logic            ge;
    logic [WORD_W:0] rn;

    always_comb begin
        n_st.pass = i_st.pass;
        n_st.mag  = i_st.mag;
        ge        = 1'b0;
        rn        = '0;
        for (int k = 0; k < LANES; k++) begin
            ge        = i_st.r[k] >= {1'b0, i_st.mag};
            rn        = ge ? (i_st.r[k] - {1'b0, i_st.mag}) : i_st.r[k];
            n_st.r[k] = {rn[WORD_W-1:0], 1'b0};
            n_st.q[k] = {i_st.q[k][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;
endmodule

>>> rtl/core/vector3_normalize_top.sv
// pipeline: prep registers, square-root cell chain, divide cell chain, output register
// throughput: one vector per cycle; every cell of the square-root and divide
// chains moves its item on in each cycle the output register is free or taken
// the whole chain holds while a result waits in the output register
// reset (synchronous, active low) clears all valid flags; data is not reset
module vector3_normalize_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    v3n_in_if.sink       i_vec,
    v3n_out_if.source    o_vec
);
    import v3n_pkg::*;

    logic     en;
    t_pass    in_pass;
    logic     sq_v [0:SQRT_STEPS];
    t_sqrt_st sq_d [0:SQRT_STEPS];
    logic     dv_v [0:DIV_STEPS];
    t_div_st  dv_d [0:DIV_STEPS];

    logic                         r_out_valid;
    logic [LANES-1:0][WORD_W-1:0] r_out_comp;
    logic [WORD_W-1:0]            r_out_len;
    logic [LANES-1:0][WORD_W-1:0] n_out_comp;
    logic [WORD_W-1:0]            n_out_len;
    logic [WORD_W-1:0]            qx;

    assign en          = !r_out_valid || o_vec.ready;
    assign i_vec.ready = en;

    assign in_pass.comp[0] = i_vec.x_in;
    assign in_pass.comp[1] = i_vec.y_in;
    assign in_pass.comp[2] = i_vec.z_in;
    assign in_pass.polar   = i_vec.is_polar;

    v3n_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_vec.valid),
        .i_pass  (in_pass),
        .o_valid (sq_v[0]),
        .o_st    (sq_d[0])
    );

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        v3n_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_st    (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_st    (sq_d[g+1])
        );
    end

    always_comb begin
        dv_v[0]      = sq_v[SQRT_STEPS];
        dv_d[0].pass = sq_d[SQRT_STEPS].pass;
        dv_d[0].mag  = sq_d[SQRT_STEPS].root;
        for (int k = 0; k < LANES; k++) begin
            dv_d[0].r[k] = {1'b0, abs_word(sq_d[SQRT_STEPS].pass.comp[k])};
            dv_d[0].q[k] = '0;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        v3n_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_st    (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_st    (dv_d[g+1])
        );
    end

    always_comb begin
        qx = '0;
        for (int k = 0; k < LANES; k++) begin
            qx = {{(WORD_W-Q_W){1'b0}}, dv_d[DIV_STEPS].q[k]};
            if (dv_d[DIV_STEPS].pass.polar) begin
                n_out_comp[k] = dv_d[DIV_STEPS].pass.comp[k];
            end else if (dv_d[DIV_STEPS].mag == '0) begin
                n_out_comp[k] = '0;
            end else if (dv_d[DIV_STEPS].pass.comp[k][WORD_W-1]) begin
                n_out_comp[k] = WORD_W'(0) - qx;
            end else begin
                n_out_comp[k] = qx;
            end
        end
        if (dv_d[DIV_STEPS].pass.polar) begin
            n_out_len = dv_d[DIV_STEPS].pass.comp[2][WORD_W-1] ? '0
                                                               : dv_d[DIV_STEPS].pass.comp[2];
        end else begin
            n_out_len = dv_d[DIV_STEPS].mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_comp <= n_out_comp;
            r_out_len  <= n_out_len;
        end
    end

    assign o_vec.valid  = r_out_valid;
    assign o_vec.x_out  = r_out_comp[0];
    assign o_vec.y_out  = r_out_comp[1];
    assign o_vec.z_out  = r_out_comp[2];
    assign o_vec.length = r_out_len;
endmodule

>>> rtl/core/v3n_checker.sv
module v3n_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_x_out,
    input logic [31:0] i_y_out,
    input logic [31:0] i_z_out,
    input logic [31:0] i_length
);
    // output empties after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_x_out)
        && $stable(i_y_out) && $stable(i_z_out) && $stable(i_length))
        else $error("stalled result changed");

    // input side stalls only while a result waits
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready mismatch");

    // an idle chain cannot produce a result in the cycle after a fresh start
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result too early after reset");
endmodule

bind vector3_normalize_top v3n_checker u_v3n_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_vec.valid),
    .i_out_ready (o_vec.ready),
    .i_x_out     (o_vec.x_out),
    .i_y_out     (o_vec.y_out),
    .i_z_out     (o_vec.z_out),
    .i_length    (o_vec.length)
);
